/* sv/ade_pkg.sv */
package ade_pkg;

  localparam int NUM_AXES    = 6;
  // The axis field is 3 bits wide, so at most eight axes can be addressed.
  localparam int STORE_DEPTH = (NUM_AXES > 8) ? 8 : NUM_AXES;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [3:0] AXIS_LIMIT = 4'(STORE_DEPTH);

  localparam int AXIS_W    = 3;
  localparam int SAMPLE_W  = 16;
  localparam int THR_W     = 16;
  localparam int VAL_W     = 16;
  localparam int QUO_W     = 15;
  localparam int DIV_STEPS = 15;
  localparam int STEP_W    = 4;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [QUO_W-1:0]        FULL_SCALE = 15'd16384;
  localparam logic [QUO_W-1:0]        ZERO_SCALE = 15'd0;
  localparam logic signed [VAL_W-1:0] HALF_POS   = 16'sd8192;
  localparam logic signed [VAL_W-1:0] HALF_NEG   = -16'sd8192;

  localparam logic [THR_W-1:0] LOWER_RESET = 16'd0;
  localparam logic [THR_W-1:0] UPPER_RESET = 16'd32768;

  // Register index, taken from paddr[2].
  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EVAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [THR_W-1:0] num;
    logic [THR_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [1:0] count;
    logic       press0;
    logic       dir0;
    logic       press1;
    logic       dir1;
  } evt_t;

endpackage

/* sv/ade_div.sv */
module ade_div (
  input  logic                      clk,
  input  logic                      rst,
  input  ade_pkg::div_req_t         req,
  output logic                      busy,
  output logic                      done,
  output logic [ade_pkg::QUO_W-1:0] quo
);
  import ade_pkg::*;

  logic [THR_W-1:0]  rem;
  logic [THR_W-1:0]  den;
  logic [QUO_W-1:0]  feed;
  logic [STEP_W-1:0] step;
  logic [THR_W:0]    trial;
  logic [THR_W:0]    diff;
  logic              take;

  // One restoring step per cycle: shift in a dividend bit, subtract if it fits.
  assign trial = {rem, feed[QUO_W-1]};
  assign diff  = trial - {1'b0, den};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend is num << 14; its top bits (num >> 1) are already below den.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.num[THR_W-1:1]};
      feed <= {req.num[0], {(QUO_W-1){1'b0}}};
      den  <= req.den;
      quo  <= '0;
    end else if (busy) begin
      rem  <= take ? diff[THR_W-1:0] : trial[THR_W-1:0];
      feed <= {feed[QUO_W-2:0], 1'b0};
      quo  <= {quo[QUO_W-2:0], take};
    end
  end

endmodule

/* sv/ade_evt.sv */
module ade_evt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              upd,
  input  logic [ade_pkg::AXIS_W-1:0]        axis,
  input  logic signed [ade_pkg::VAL_W-1:0]  nv,
  output ade_pkg::evt_t                     evt
);
  import ade_pkg::*;

  logic signed [VAL_W-1:0] prev [STORE_DEPTH];
  logic signed [VAL_W-1:0] ov;
  logic                    in_range;
  logic [IDX_W-1:0]        idx;

  assign in_range = {1'b0, axis} < AXIS_LIMIT;
  assign idx      = axis[IDX_W-1:0];
  assign ov       = in_range ? prev[idx] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        prev[i] <= '0;
      end
    end else if (upd && in_range) begin
      prev[idx] <= nv;
    end
  end

  // Release before press; an old value exactly on +/-half gives nothing.
  always_comb begin
    evt = '0;
    if (in_range) begin
      if (ov > HALF_NEG && ov < HALF_POS) begin
        if (nv < HALF_NEG) begin
          evt.count  = 2'd1;
          evt.press0 = 1'b1;
          evt.dir0   = 1'b0;
        end else if (nv > HALF_POS) begin
          evt.count  = 2'd1;
          evt.press0 = 1'b1;
          evt.dir0   = 1'b1;
        end
      end else if (ov < HALF_NEG) begin
        if (nv >= HALF_NEG) begin
          evt.count  = 2'd1;
          evt.press0 = 1'b0;
          evt.dir0   = 1'b0;
          if (nv > HALF_POS) begin
            evt.count  = 2'd2;
            evt.press1 = 1'b1;
            evt.dir1   = 1'b1;
          end
        end
      end else if (ov > HALF_POS) begin
        if (nv <= HALF_POS) begin
          evt.count  = 2'd1;
          evt.press0 = 1'b0;
          evt.dir0   = 1'b1;
          if (nv < HALF_NEG) begin
            evt.count  = 2'd2;
            evt.press1 = 1'b1;
            evt.dir1   = 1'b0;
          end
        end
      end
    end
  end

endmodule

/* sv/axis_deadzone_direction_events.sv */
// Channel   Direction  Handshake            Payload
// config    in         psel/penable/pwrite  paddr, pwdata, prdata (APB, pready tied high)
// input     in         in_valid / in_stall  axis_index, sample
// result    out        out_valid/out_stall  axis_out, scaled_value, has_event, is_press,
//                                           direction, last
//
// An item is taken only in IDLE and runs PREP, DIV, EVAL, EMIT one at a time.
// With a division it passes IDLE, PREP, DIV (the serial divider, one quotient
// bit per cycle), EVAL and EMIT. Without one (dead zone, full scale, equal
// thresholds) DIV is skipped. Each event beyond the first adds a load in EMIT.
// Reset (rst, synchronous) clears the sequencer, the output valid, the
// per-axis stored values and the thresholds (lower 0, upper 32768).
// A stall on the result side holds the output register; the last result of an
// item may still wait there while the next item is transferred in.
module axis_deadzone_direction_events (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ade_pkg::PADDR_W-1:0]         paddr,
  input  logic [ade_pkg::PDATA_W-1:0]         pwdata,
  output logic [ade_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ade_pkg::AXIS_W-1:0]          axis_index,
  input  logic signed [ade_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ade_pkg::AXIS_W-1:0]          axis_out,
  output logic signed [ade_pkg::VAL_W-1:0]    scaled_value,
  output logic                                has_event,
  output logic                                is_press,
  output logic                                direction,
  output logic                                last
);
  import ade_pkg::*;

  // Threshold registers
  logic [THR_W-1:0] lower_threshold;
  logic [THR_W-1:0] upper_threshold;

  // Sequencer and per-item working registers
  state_t                  state;
  state_t                  state_next;
  logic [AXIS_W-1:0]       ax;
  logic                    neg;
  logic [THR_W-1:0]        mag;
  logic [QUO_W-1:0]        mval;
  logic signed [VAL_W-1:0] nv;
  evt_t                    evt;
  logic                    k;

  // Combinational helpers
  logic                    cfg_write;
  logic                    in_xfer;
  logic                    below;
  logic                    above;
  logic                    flat;
  logic                    need_div;
  logic                    upd;
  logic                    emit_load;
  logic                    is_final;
  logic signed [VAL_W-1:0] nv_calc;
  evt_t                    evt_calc;
  div_req_t                div_req;
  logic                    div_busy;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;

  // ---------------------------------------------------------------------------
  // Configuration port: zero-wait APB, index from paddr[2]
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_threshold <= LOWER_RESET;
      upper_threshold <= UPPER_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_LOWER: lower_threshold <= pwdata[THR_W-1:0];
        REG_UPPER: upper_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LOWER: prdata = {{(PDATA_W-THR_W){1'b0}}, lower_threshold};
      REG_UPPER: prdata = {{(PDATA_W-THR_W){1'b0}}, upper_threshold};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Dead zone decision on the registered magnitude
  // ---------------------------------------------------------------------------
  assign in_xfer  = in_valid && !in_stall;
  assign below    = mag < lower_threshold;
  assign above    = mag > upper_threshold;
  assign flat     = upper_threshold == lower_threshold;
  assign need_div = !below && !above && !flat;

  assign div_req.start = (state == ST_PREP) && need_div;
  assign div_req.num   = mag - lower_threshold;
  assign div_req.den   = upper_threshold - lower_threshold;

  ade_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  // Apply the sample's sign to the unsigned Q1.14 magnitude.
  assign nv_calc = neg ? -$signed({1'b0, mval}) : $signed({1'b0, mval});

  ade_evt u_evt (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .axis (ax),
    .nv   (nv_calc),
    .evt  (evt_calc)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign is_final = (evt.count != 2'd2) || k;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_PREP;
      ST_PREP: state_next = need_div ? ST_DIV : ST_EVAL;
      ST_DIV:  if (div_done) state_next = ST_EVAL;
      ST_EVAL: state_next = ST_EMIT;
      ST_EMIT: if (emit_load && is_final) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    upd       = 1'b0;
    emit_load = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EVAL: upd = 1'b1;
      ST_EMIT: emit_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers: capture the sample, hold the magnitude through the
  // division, then latch the signed value and its events for emission.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ax  <= axis_index;
      neg <= sample[SAMPLE_W-1];
      mag <= sample[SAMPLE_W-1] ? THR_W'(-sample) : THR_W'(sample);
    end
    if (state == ST_PREP) begin
      mval <= (!below && above) ? FULL_SCALE : ZERO_SCALE;
    end
    if (div_done) begin
      mval <= div_quo;
    end
    if (upd) begin
      nv  <= nv_calc;
      evt <= evt_calc;
      k   <= 1'b0;
    end else if (emit_load) begin
      k <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      axis_out     <= ax;
      scaled_value <= nv;
      last         <= is_final;
      if (evt.count == 2'd0) begin
        has_event <= 1'b0;
        is_press  <= 1'b0;
        direction <= 1'b0;
      end else begin
        has_event <= 1'b1;
        is_press  <= k ? evt.press1 : evt.press0;
        direction <= k ? evt.dir1 : evt.dir0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_accept_to_prep: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_PREP))
    else $error("accepted sample did not enter the prepare state");

  a_no_event_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_event) |-> (last && !is_press && !direction))
    else $error("result without event carries event fields or is not last");

  a_final_load: assert property (@(posedge clk) disable iff (rst)
    (emit_load && is_final) |=> (out_valid && last && (state == ST_IDLE)))
    else $error("final result not presented as last");

  a_div_idle_outside: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIV))
    else $error("divider running outside the divide state");
`endif

endmodule
